/* sv/i2cm_pkg.sv */
// Package for the I2C master transfer sequencer: item types, phase enum and codes.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

    // Commands carried by an input item
    localparam logic CMD_BEGIN     = 1'b0;
    localparam logic CMD_BYTE_DONE = 1'b1;

    // Bus actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_START   = 3'd1;
    localparam logic [2:0] ACT_RSTART  = 3'd2;
    localparam logic [2:0] ACT_SEND    = 3'd3;
    localparam logic [2:0] ACT_RX_ACK  = 3'd4;
    localparam logic [2:0] ACT_RX_NACK = 3'd5;
    localparam logic [2:0] ACT_STOP    = 3'd6;

    // Transfer status
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BUSY     = 3'd1;
    localparam logic [2:0] ST_ARB      = 3'd2;
    localparam logic [2:0] ST_NAK      = 3'd3;
    localparam logic [2:0] ST_ADDR_NAK = 3'd4;

    // Reset value of the bit-rate divider code
    localparam logic [5:0] CLK_DIV_RESET = 6'd21;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'd0,
        PH_ADDR   = 3'd1,
        PH_REG    = 3'd2,
        PH_RSTART = 3'd3,
        PH_WRITE  = 3'd4,
        PH_READ   = 3'd5
    } t_phase;

    typedef struct packed {
        logic        command;
        logic [6:0]  slave_address;
        logic        read_transfer;
        logic [31:0] register_address;
        logic [2:0]  register_address_bytes;
        logic [8:0]  byte_count;
        logic [7:0]  tx_byte;
        logic [7:0]  rx_byte;
        logic        nak_seen;
        logic        arbitration_lost;
        logic        bus_busy;
    } t_in_item;

    typedef struct packed {
        logic [2:0] bus_action;
        logic [7:0] bus_byte;
        logic       read_valid;
        logic [7:0] read_byte;
        logic       done_res;
        logic [2:0] status;
    } t_out_item;

endpackage

`default_nettype wire

/* sv/i2cm_in_stage.sv */
// Input register of the sequencer: holds one accepted item until the core takes it.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_in_stage
    import i2cm_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_item,
    output logic          o_valid,
    input  wire logic     i_take,
    output t_in_item      o_item
);

    logic     r_valid;
    t_in_item r_item;

    // Free when empty or when the held item leaves this cycle
    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    // Payload, no reset
    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

/* sv/i2cm_core.sv */
// Transfer state and the per-item step logic of the sequencer.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_core
    import i2cm_pkg::*;
#(
    parameter int MAX_TRANSFER_BYTES = 256,
    parameter int MAX_REGISTER_BYTES = 4
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_step,
    input  wire t_in_item i_item,
    output t_out_item     o_result
);

    localparam int CW = $clog2(MAX_TRANSFER_BYTES + 1);

    t_phase      r_phase, n_phase;
    logic [6:0]  r_target_address, n_target_address;
    logic        r_reading, n_reading;
    logic [31:0] r_register_shift, n_register_shift;
    logic [2:0]  r_reg_left, n_reg_left;
    logic [CW-1:0] r_data_left, n_data_left;

    logic [2:0]    reg_sat;
    logic [CW-1:0] cnt_sat;
    logic [CW-1:0] read_left;
    logic [2:0]    reg_next;
    logic          go_data;

    // Saturated begin fields
    always_comb begin
        if ({29'd0, i_item.register_address_bytes} > 32'(MAX_REGISTER_BYTES)) begin
            reg_sat = 3'(MAX_REGISTER_BYTES);
        end else begin
            reg_sat = i_item.register_address_bytes;
        end
        if ({23'd0, i_item.byte_count} > 32'(MAX_TRANSFER_BYTES)) begin
            cnt_sat = CW'(MAX_TRANSFER_BYTES);
        end else begin
            cnt_sat = CW'(i_item.byte_count);
        end
    end

    assign read_left = (r_data_left != '0) ? r_data_left - CW'(1) : '0;
    assign reg_next  = r_reg_left - 3'd1;

    // Step logic: next state and the result of one item
    always_comb begin
        n_phase          = r_phase;
        n_target_address = r_target_address;
        n_reading        = r_reading;
        n_register_shift = r_register_shift;
        n_reg_left       = r_reg_left;
        n_data_left      = r_data_left;
        o_result         = '0;
        go_data          = 1'b0;

        if (i_item.command == CMD_BEGIN) begin
            if (r_phase != PH_IDLE) begin
                o_result.bus_action = ACT_NONE;
            end else if (i_item.bus_busy) begin
                o_result.done_res = 1'b1;
                o_result.status   = ST_BUSY;
            end else begin
                n_target_address    = i_item.slave_address;
                n_reading           = i_item.read_transfer;
                n_register_shift    = i_item.register_address;
                n_reg_left          = reg_sat;
                n_data_left         = cnt_sat;
                n_phase             = PH_ADDR;
                o_result.bus_action = ACT_START;
                o_result.bus_byte   = {i_item.slave_address,
                                       i_item.read_transfer && (reg_sat == 3'd0)};
            end
        end else if (r_phase == PH_IDLE) begin
            o_result.bus_action = ACT_NONE;
        end else if (r_phase == PH_READ) begin
            // Master drives the ACK, so no error check here
            n_data_left         = read_left;
            o_result.read_valid = 1'b1;
            o_result.read_byte  = i_item.rx_byte;
            if (read_left == '0) begin
                n_phase             = PH_IDLE;
                o_result.bus_action = ACT_STOP;
                o_result.done_res   = 1'b1;
                o_result.status     = ST_OK;
            end else begin
                o_result.bus_action = (read_left == CW'(1)) ? ACT_RX_NACK : ACT_RX_ACK;
            end
        end else if (i_item.arbitration_lost || i_item.nak_seen) begin
            // Arbitration lost wins over NAK
            n_phase             = PH_IDLE;
            n_reg_left          = 3'd0;
            n_data_left         = '0;
            o_result.bus_action = ACT_STOP;
            o_result.done_res   = 1'b1;
            if (i_item.arbitration_lost) begin
                o_result.status = ST_ARB;
            end else if (r_phase == PH_RSTART) begin
                o_result.status = ST_ADDR_NAK;
            end else begin
                o_result.status = ST_NAK;
            end
        end else if (r_phase == PH_ADDR || r_phase == PH_REG) begin
            if (r_reg_left != 3'd0) begin
                // Register bytes, most significant first
                n_reg_left          = reg_next;
                n_phase             = PH_REG;
                o_result.bus_action = ACT_SEND;
                case (reg_next[1:0])
                    2'd0:    o_result.bus_byte = r_register_shift[7:0];
                    2'd1:    o_result.bus_byte = r_register_shift[15:8];
                    2'd2:    o_result.bus_byte = r_register_shift[23:16];
                    2'd3:    o_result.bus_byte = r_register_shift[31:24];
                    default: o_result.bus_byte = 8'd0;
                endcase
            end else if (r_phase == PH_REG && r_reading) begin
                n_phase             = PH_RSTART;
                o_result.bus_action = ACT_RSTART;
                o_result.bus_byte   = {r_target_address, 1'b1};
            end else begin
                go_data = 1'b1;
            end
        end else if (r_phase == PH_RSTART) begin
            go_data = 1'b1;
        end else if (r_phase == PH_WRITE) begin
            if (r_data_left != '0) begin
                n_data_left         = r_data_left - CW'(1);
                o_result.bus_action = ACT_SEND;
                o_result.bus_byte   = i_item.tx_byte;
            end else begin
                n_phase             = PH_IDLE;
                o_result.bus_action = ACT_STOP;
                o_result.done_res   = 1'b1;
                o_result.status     = ST_OK;
            end
        end else begin
            n_phase = PH_IDLE;
        end

        // Entry to the data phase after address and register bytes
        if (go_data) begin
            if (r_data_left == '0) begin
                n_phase             = PH_IDLE;
                o_result.bus_action = ACT_STOP;
                o_result.done_res   = 1'b1;
                o_result.status     = ST_OK;
            end else if (r_reading) begin
                n_phase             = PH_READ;
                o_result.bus_action = (r_data_left == CW'(1)) ? ACT_RX_NACK : ACT_RX_ACK;
            end else begin
                n_data_left         = r_data_left - CW'(1);
                n_phase             = PH_WRITE;
                o_result.bus_action = ACT_SEND;
                o_result.bus_byte   = i_item.tx_byte;
            end
        end
    end

    // Transfer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase          <= PH_IDLE;
            r_target_address <= 7'd0;
            r_reading        <= 1'b0;
            r_register_shift <= 32'd0;
            r_reg_left       <= 3'd0;
            r_data_left      <= '0;
        end else if (i_step) begin
            r_phase          <= n_phase;
            r_target_address <= n_target_address;
            r_reading        <= n_reading;
            r_register_shift <= n_register_shift;
            r_reg_left       <= n_reg_left;
            r_data_left      <= n_data_left;
        end
    end

endmodule

`default_nettype wire

/* sv/i2cm_out_stage.sv */
// Result register of the sequencer: holds one result item until it is taken.
// Depends on i2cm_pkg.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_out_stage
    import i2cm_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_out_item i_item,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_item
);

    logic      r_valid;
    t_out_item r_item;

    // Free when empty or when the held result is taken this cycle
    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

`default_nettype wire

/* sv/i2c_master_transfer_sequencer.sv */
// I2C master transfer sequencer, top level: input register, step logic, result register.
// An accepted item waits in the input register until the result register is free.
// Throughput: one item per cycle; a result held by a stalled output stops the input register.
// Reset (synchronous, active low): sequencer idle, both stages empty, divider code 21.
// Depends on i2cm_pkg, i2cm_in_stage, i2cm_core and i2cm_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module i2c_master_transfer_sequencer
    import i2cm_pkg::*;
#(
    parameter int MAX_TRANSFER_BYTES = 256,
    parameter int MAX_REGISTER_BYTES = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // Configuration
    input  wire logic        i_cfg_wr_en,
    input  wire logic [5:0]  i_cfg_wr_data,
    // Input items
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_command,
    input  wire logic [6:0]  i_slave_address,
    input  wire logic        i_read_transfer,
    input  wire logic [31:0] i_register_address,
    input  wire logic [2:0]  i_register_address_bytes,
    input  wire logic [8:0]  i_byte_count,
    input  wire logic [7:0]  i_tx_byte,
    input  wire logic [7:0]  i_rx_byte,
    input  wire logic        i_nak_seen,
    input  wire logic        i_arbitration_lost,
    input  wire logic        i_bus_busy,
    // Result items
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [2:0]       o_bus_action,
    output logic [7:0]       o_bus_byte,
    output logic             o_read_valid,
    output logic [7:0]       o_read_byte,
    output logic             o_done_res,
    output logic [2:0]       o_status
);

    t_in_item  in_item, held_item;
    t_out_item step_result, out_item;
    logic      held_valid;
    logic      out_free;
    logic      step;

    // Divider code for the bus timing logic; held only
    logic [5:0] r_clock_divider_code;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_divider_code <= CLK_DIV_RESET;
        end else if (i_cfg_wr_en) begin
            r_clock_divider_code <= i_cfg_wr_data;
        end
    end

    assign in_item = '{
        command:                i_command,
        slave_address:          i_slave_address,
        read_transfer:          i_read_transfer,
        register_address:       i_register_address,
        register_address_bytes: i_register_address_bytes,
        byte_count:             i_byte_count,
        tx_byte:                i_tx_byte,
        rx_byte:                i_rx_byte,
        nak_seen:               i_nak_seen,
        arbitration_lost:       i_arbitration_lost,
        bus_busy:               i_bus_busy
    };

    // Held item is stepped when the result register can take its result
    assign step = held_valid && out_free;

    i2cm_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (in_item),
        .o_valid (held_valid),
        .i_take  (out_free),
        .o_item  (held_item)
    );

    i2cm_core #(
        .MAX_TRANSFER_BYTES (MAX_TRANSFER_BYTES),
        .MAX_REGISTER_BYTES (MAX_REGISTER_BYTES)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (step),
        .i_item   (held_item),
        .o_result (step_result)
    );

    i2cm_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (held_valid),
        .o_ready (out_free),
        .i_item  (step_result),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_item  (out_item)
    );

    assign o_bus_action = out_item.bus_action;
    assign o_bus_byte   = out_item.bus_byte;
    assign o_read_valid = out_item.read_valid;
    assign o_read_byte  = out_item.read_byte;
    assign o_done_res   = out_item.done_res;
    assign o_status     = out_item.status;

endmodule

`default_nettype wire
